/* src/brp_pkg.sv */
// ----------------------------------------------------------------------------
// brp_pkg
// types, register codes and mask helpers shared by the pixel repacker
// ----------------------------------------------------------------------------
`default_nettype none

package brp_pkg;

	localparam int PIXEL_W    = 32;
	localparam int OUT_W      = 32;
	localparam int CFG_DATA_W = 32;
	localparam int REG_IDX_W  = 3;
	localparam int NUM_CHAN   = 4;
	localparam int CHAN_W     = 8;
	localparam int QUEUE_DEPTH = 2;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_RED_MASK   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_GREEN_MASK = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_BLUE_MASK  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_ALPHA_MASK = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_RED_BITS   = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_GREEN_BITS = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_BLUE_BITS  = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_ALPHA_BITS = 3'd7;

	// channel slots
	localparam int CH_RED   = 0;
	localparam int CH_GREEN = 1;
	localparam int CH_BLUE  = 2;
	localparam int CH_ALPHA = 3;

	localparam logic [31:0] RED_MASK_RESET   = 32'h00FF_0000;
	localparam logic [31:0] GREEN_MASK_RESET = 32'h0000_FF00;
	localparam logic [31:0] BLUE_MASK_RESET  = 32'h0000_00FF;
	localparam logic [31:0] ALPHA_MASK_RESET = 32'hFF00_0000;
	localparam logic [3:0]  RED_BITS_RESET   = 4'd5;
	localparam logic [3:0]  GREEN_BITS_RESET = 4'd6;
	localparam logic [3:0]  BLUE_BITS_RESET  = 4'd5;
	localparam logic [3:0]  ALPHA_BITS_RESET = 4'd0;
	localparam logic [3:0]  TARGET_MAX       = 4'd8;

	typedef struct packed {
		logic [4:0] off;
		logic [4:0] len;
		logic [3:0] tgt;
	} chan_cfg_t;

	typedef struct packed {
		logic [PIXEL_W-1:0] color;
		logic [5:0]         bpp;
		logic               last;
	} item_t;

	// trailing zeros, then the run of ones above them (capped at 31)
	function automatic chan_cfg_t mask_geom(input logic [31:0] mask);
		logic [31:0] m;
		logic [4:0]  o;
		logic [4:0]  n;
		chan_cfg_t   g;
		m = mask;
		o = '0;
		n = '0;
		if (m[15:0] == 16'h0) begin o = o + 5'd16; m = m >> 16; end
		if (m[7:0] == 8'h0) begin o = o + 5'd8; m = m >> 8; end
		if (m[3:0] == 4'h0) begin o = o + 5'd4; m = m >> 4; end
		if (m[1:0] == 2'h0) begin o = o + 5'd2; m = m >> 2; end
		if (m[0] == 1'b0) begin o = o + 5'd1; m = m >> 1; end
		m = ~m;
		if (m[15:0] == 16'h0) begin n = n + 5'd16; m = m >> 16; end
		if (m[7:0] == 8'h0) begin n = n + 5'd8; m = m >> 8; end
		if (m[3:0] == 4'h0) begin n = n + 5'd4; m = m >> 4; end
		if (m[1:0] == 2'h0) begin n = n + 5'd2; m = m >> 2; end
		if (m[0] == 1'b0) begin n = n + 5'd1; end
		g.off = o;
		g.len = n;
		g.tgt = '0;
		return g;
	endfunction

	function automatic logic [3:0] clamp_target(input logic [3:0] t);
		return (t > TARGET_MAX) ? TARGET_MAX : t;
	endfunction

	// pull one field out and scale it to the target width
	function automatic logic [CHAN_W-1:0] chan_value(input logic [PIXEL_W-1:0] pix,
			input chan_cfg_t c);
		logic [31:0] lmask;
		logic [31:0] f;
		logic [31:0] v;
		lmask = ~(32'hFFFF_FFFF << c.len);
		f = (pix >> c.off) & lmask;
		if ({1'b0, c.tgt} < c.len) begin
			v = f >> (c.len - {1'b0, c.tgt});
		end else begin
			v = f << ({1'b0, c.tgt} - c.len);
		end
		return v[CHAN_W-1:0];
	endfunction

endpackage

`default_nettype wire

/* src/brp_pixel_if.sv */
// ----------------------------------------------------------------------------
// brp_pixel_if
// raw pixel request channel
// ----------------------------------------------------------------------------
`default_nettype none

interface brp_pixel_if import brp_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [PIXEL_W-1:0] pixel_value;
	logic               last_pixel;

	modport source(output valid, pixel_value, last_pixel, input ready);
	modport sink(input valid, pixel_value, last_pixel, output ready);
endinterface

`default_nettype wire

/* src/brp_word_if.sv */
// ----------------------------------------------------------------------------
// brp_word_if
// packed word request channel
// ----------------------------------------------------------------------------
`default_nettype none

interface brp_word_if import brp_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [OUT_W-1:0] packed_word;
	logic             final_word;

	modport source(output valid, packed_word, final_word, input ready);
	modport sink(input valid, packed_word, final_word, output ready);
endinterface

`default_nettype wire

/* src/brp_config.sv */
// ----------------------------------------------------------------------------
// brp_config
// configuration registers, mask geometry worked out on each write
// ----------------------------------------------------------------------------
`default_nettype none

module brp_config import brp_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [REG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	output chan_cfg_t [NUM_CHAN-1:0]   chan_cfg
);

	// geometry of the reset masks
	localparam chan_cfg_t RED_RESET_GEOM   = mask_geom(RED_MASK_RESET);
	localparam chan_cfg_t GREEN_RESET_GEOM = mask_geom(GREEN_MASK_RESET);
	localparam chan_cfg_t BLUE_RESET_GEOM  = mask_geom(BLUE_MASK_RESET);
	localparam chan_cfg_t ALPHA_RESET_GEOM = mask_geom(ALPHA_MASK_RESET);

	chan_cfg_t [NUM_CHAN-1:0] cfg_q;
	chan_cfg_t                wr_geom;
	logic [3:0]               wr_tgt;

	assign wr_geom = mask_geom(cfg_wdata);
	assign wr_tgt  = clamp_target(cfg_wdata[3:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q[CH_RED]   <= '{off: RED_RESET_GEOM.off, len: RED_RESET_GEOM.len,
				tgt: RED_BITS_RESET};
			cfg_q[CH_GREEN] <= '{off: GREEN_RESET_GEOM.off, len: GREEN_RESET_GEOM.len,
				tgt: GREEN_BITS_RESET};
			cfg_q[CH_BLUE]  <= '{off: BLUE_RESET_GEOM.off, len: BLUE_RESET_GEOM.len,
				tgt: BLUE_BITS_RESET};
			cfg_q[CH_ALPHA] <= '{off: ALPHA_RESET_GEOM.off, len: ALPHA_RESET_GEOM.len,
				tgt: ALPHA_BITS_RESET};
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RED_MASK: begin
					cfg_q[CH_RED].off <= wr_geom.off;
					cfg_q[CH_RED].len <= wr_geom.len;
				end
				REG_GREEN_MASK: begin
					cfg_q[CH_GREEN].off <= wr_geom.off;
					cfg_q[CH_GREEN].len <= wr_geom.len;
				end
				REG_BLUE_MASK: begin
					cfg_q[CH_BLUE].off <= wr_geom.off;
					cfg_q[CH_BLUE].len <= wr_geom.len;
				end
				REG_ALPHA_MASK: begin
					cfg_q[CH_ALPHA].off <= wr_geom.off;
					cfg_q[CH_ALPHA].len <= wr_geom.len;
				end
				REG_RED_BITS:   cfg_q[CH_RED].tgt   <= wr_tgt;
				REG_GREEN_BITS: cfg_q[CH_GREEN].tgt <= wr_tgt;
				REG_BLUE_BITS:  cfg_q[CH_BLUE].tgt  <= wr_tgt;
				REG_ALPHA_BITS: cfg_q[CH_ALPHA].tgt <= wr_tgt;
				default: ;
			endcase
		end
	end

	assign chan_cfg = cfg_q;

endmodule

`default_nettype wire

/* src/brp_front.sv */
// ----------------------------------------------------------------------------
// brp_front
// takes pixels, extracts and scales the four fields, forms the packed pixel
// ----------------------------------------------------------------------------
`default_nettype none

module brp_front import brp_pkg::*; (
	brp_pixel_if.sink                pixels,
	input  chan_cfg_t [NUM_CHAN-1:0] chan_cfg,
	input  wire logic                q_full,
	output logic                     q_push,
	output item_t                    q_item
);

	logic [CHAN_W-1:0] r_v, g_v, b_v, a_v;
	logic [3:0]        rt, gt, bt, at;
	logic [4:0]        b_pos, a_pos;

	assign rt = chan_cfg[CH_RED].tgt;
	assign gt = chan_cfg[CH_GREEN].tgt;
	assign bt = chan_cfg[CH_BLUE].tgt;
	assign at = chan_cfg[CH_ALPHA].tgt;

	assign r_v = chan_value(pixels.pixel_value, chan_cfg[CH_RED]);
	assign g_v = chan_value(pixels.pixel_value, chan_cfg[CH_GREEN]);
	assign b_v = chan_value(pixels.pixel_value, chan_cfg[CH_BLUE]);
	assign a_v = chan_value(pixels.pixel_value, chan_cfg[CH_ALPHA]);

	assign b_pos = {1'b0, rt} + {1'b0, gt};
	assign a_pos = b_pos + {1'b0, bt};

	// red low, alpha high
	assign q_item.color = PIXEL_W'(r_v)
		| (PIXEL_W'(g_v) << rt)
		| (PIXEL_W'(b_v) << b_pos)
		| (PIXEL_W'(a_v) << a_pos);
	assign q_item.bpp  = {2'b00, rt} + {2'b00, gt} + {2'b00, bt} + {2'b00, at};
	assign q_item.last = pixels.last_pixel;

	assign pixels.ready = !q_full;
	assign q_push       = pixels.valid && !q_full;

endmodule

`default_nettype wire

/* src/brp_queue.sv */
// ----------------------------------------------------------------------------
// brp_queue
// short queue between the front and the packing back end
// ----------------------------------------------------------------------------
`default_nettype none

module brp_queue import brp_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  item_t     push_item,
	input  wire logic pop,
	output logic      full,
	output logic      head_valid,
	output item_t     head_item
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	item_t              mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full       = (count_q == CNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

/* src/brp_back.sv */
// ----------------------------------------------------------------------------
// brp_back
// packs pixels into words, handles the end-of-image flush, output register
// ----------------------------------------------------------------------------
`default_nettype none

module brp_back import brp_pkg::*; #(
	parameter int WORD_WIDTH = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic q_valid,
	input  item_t     q_item,
	output logic      q_pop,
	brp_word_if.source words
);

	localparam int FILL_W = $clog2(WORD_WIDTH);
	localparam int SUM_W  = FILL_W + 2;
	localparam int WIDE_W = WORD_WIDTH + OUT_W;

	logic [WORD_WIDTH-1:0] acc_q;
	logic [FILL_W-1:0]     fill_q;
	logic                  pend_valid_q;
	logic [OUT_W-1:0]      pend_word_q;
	logic                  out_valid_q;
	logic [OUT_W-1:0]      out_word_q;
	logic                  out_final_q;

	logic [SUM_W-1:0]      sum;
	logic                  full_word;
	logic [WIDE_W-1:0]     wide;
	logic [SUM_W-1:0]      new_sum;
	logic [FILL_W-1:0]     new_fill;
	logic [WORD_WIDTH-1:0] new_acc;
	logic                  flush;
	logic                  needs_out;
	logic                  out_free;

	assign sum       = SUM_W'(fill_q) + SUM_W'(q_item.bpp);
	assign full_word = (sum >= SUM_W'(WORD_WIDTH));
	assign wide      = WIDE_W'(acc_q) | (WIDE_W'(q_item.color) << fill_q);
	assign new_sum   = full_word ? (sum - SUM_W'(WORD_WIDTH)) : sum;
	assign new_fill  = new_sum[FILL_W-1:0];
	// spill-over above the word boundary starts the next word
	assign new_acc   = full_word ? WORD_WIDTH'(wide[WIDE_W-1:WORD_WIDTH])
		: wide[WORD_WIDTH-1:0];
	assign flush     = q_item.last && (new_fill != '0);
	assign needs_out = full_word || flush;

	assign out_free = !out_valid_q || words.ready;
	assign q_pop    = q_valid && !pend_valid_q && (!needs_out || out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q        <= '0;
			fill_q       <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (q_pop) begin
				if (q_item.last) begin
					acc_q  <= '0;
					fill_q <= '0;
				end else begin
					acc_q  <= new_acc;
					fill_q <= new_fill;
				end
			end
			if (pend_valid_q && out_free) begin
				pend_valid_q <= 1'b0;
				out_valid_q  <= 1'b1;
			end else if (q_pop && needs_out) begin
				pend_valid_q <= full_word && flush;
				out_valid_q  <= 1'b1;
			end else if (words.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pend_valid_q && out_free) begin
			out_word_q  <= pend_word_q;
			out_final_q <= 1'b1;
		end else if (q_pop && needs_out) begin
			if (full_word) begin
				out_word_q  <= wide[OUT_W-1:0];
				out_final_q <= q_item.last && !flush;
				pend_word_q <= new_acc[OUT_W-1:0];
			end else begin
				out_word_q  <= new_acc[OUT_W-1:0];
				out_final_q <= 1'b1;
			end
		end
	end

	assign words.valid       = out_valid_q;
	assign words.packed_word = out_word_q;
	assign words.final_word  = out_final_q;

endmodule

`default_nettype wire

/* src/bitfield_pixel_repacker.sv */
// ----------------------------------------------------------------------------
// bitfield_pixel_repacker
// unpacks bitfield pixels by channel mask and repacks them into words
// ----------------------------------------------------------------------------
// usage
//   pixels : raw pixel requests (pixel_value, last_pixel), valid/ready
//   words  : packed word requests (packed_word, final_word), valid/ready
//   cfg_*  : register writes (masks 0-3, target widths 4-7), idle only
// throughput: one pixel per cycle while words.ready is high; the front
//   extracts in the cycle of acceptance and the back packs one queued pixel
//   per cycle. a last pixel that both fills a word and leaves a remainder
//   gives two words and holds the back until the second word has moved
//   into the output register. a completing pixel is written into the queue,
//   then its word into the output register
// reset: masks and widths take their reset values, the partial word and
//   fill position clear, queue and output register empty
// stall: when words.ready is low the output register holds its word, the
//   back halts at its next word, the two-entry queue fills, pixels.ready drops
// ----------------------------------------------------------------------------
`default_nettype none

module bitfield_pixel_repacker import brp_pkg::*; #(
	parameter int WORD_WIDTH = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [REG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	brp_pixel_if.sink                  pixels,
	brp_word_if.source                 words
);

	// per-channel offset, run length and clamped target width
	chan_cfg_t [NUM_CHAN-1:0] chan_cfg;

	// front to queue
	logic  q_push;
	item_t q_push_item;
	logic  q_full;

	// queue to back
	logic  q_head_valid;
	item_t q_head_item;
	logic  q_pop;

	brp_config u_config (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.chan_cfg  (chan_cfg)
	);

	// field extraction and pixel assembly
	brp_front u_front (
		.pixels   (pixels),
		.chan_cfg (chan_cfg),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_item   (q_push_item)
	);

	// decouples acceptance from word output
	brp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_item  (q_push_item),
		.pop        (q_pop),
		.full       (q_full),
		.head_valid (q_head_valid),
		.head_item  (q_head_item)
	);

	// word packing, flush on last pixel, output register
	brp_back #(
		.WORD_WIDTH (WORD_WIDTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_head_valid),
		.q_item  (q_head_item),
		.q_pop   (q_pop),
		.words   (words)
	);

endmodule

`default_nettype wire
